FILE: rtl/core/bsh_pkg.sv
package bsh_pkg;

  // default bin memory depth
  localparam int MAX_BINS_DEF = 4096;
  // address field wide enough for the largest supported memory (16384 bins)
  localparam int ADDR_W = 14;
  // bin count in use, up to 8191
  localparam int NB_W   = 15;
  localparam int BIN_W  = 40;
  localparam int CNT_W  = 32;
  localparam int SCALE_W = 24;
  localparam int NBREG_W = 13;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS  = 2'd1;

  localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 24'd65536;
  localparam logic [NBREG_W-1:0] NUM_BINS_RST  = 13'd4096;

  // log2(e) in Q12 and exponent offset term
  localparam logic signed [29:0] LOG2E_Q12  = 30'sd5909;
  localparam logic signed [29:0] EXP_OFFS   = 30'sd268435456;
  localparam logic [23:0]        EXP_MAX    = 24'hFFFFFF;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_SKIP,
    OP_ACC,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       frac;
  } job_t;

  // 2^(j/16) in Q16, rounded
  function automatic logic [17:0] pow2_lut(input logic [4:0] j);
    logic [17:0] r;
    case (j)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      5'd16:   r = 18'd131072;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/bsh_front.sv
module bsh_front import bsh_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [15:0]          intensity,
  input  logic signed [15:0]   bias_log,
  input  logic [11:0]          bin_index,
  input  logic [SCALE_W-1:0]   bin_scale,
  input  logic [NBREG_W-1:0]   num_bins,
  input  logic                 clearing,
  output logic                 push,
  output job_t                 push_job,
  input  logic                 q_full
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_MANT,
    ST_SHIFT,
    ST_MUL,
    ST_PUSH
  } state_t;

  state_t             state;
  logic               cmd;
  logic [15:0]        inten;
  logic signed [15:0] bias;
  logic [11:0]        bidx;
  logic signed [29:0] lq;
  logic [39:0]        y0;
  logic [17:0]        mant;
  logic [4:0]         kq;
  logic [23:0]        e;
  logic [43:0]        plo;
  logic [43:0]        phi;

  logic [4:0]         lut_j;
  logic [17:0]        t0;
  logic [17:0]        t1;
  logic [12:0]        tdiff;
  logic [20:0]        tprod;
  logic [4:0]         sh_up;
  logic [25:0]        mwide;
  logic [23:0]        e_next;
  logic [63:0]        ysum;
  logic [47:0]        y;
  logic [NB_W-1:0]    nb;
  logic [NB_W-1:0]    nbm1;
  logic               acc_ok;
  job_t               acc_job;
  job_t               rd_job;

  // accept only while idle and the memory is not being cleared
  assign in_stall = (state != ST_IDLE) || clearing;

  // mantissa by table interpolation
  always_comb begin
    lut_j = {1'b0, lq[23:20]};
    t0    = pow2_lut(lut_j);
    t1    = pow2_lut(lut_j + 5'd1);
    tdiff = 13'(t1 - t0);
    tprod = 21'(tdiff) * 21'(lq[19:12]);
  end

  // scale mantissa by the integer exponent, saturating
  always_comb begin
    sh_up  = kq - 5'd16;
    mwide  = 26'(mant) << sh_up[3:0];
    if (kq >= 5'd16) begin
      if (sh_up > 5'd8 || mwide > 26'(EXP_MAX)) begin
        e_next = EXP_MAX;
      end else begin
        e_next = mwide[23:0];
      end
    end else begin
      e_next = 24'(mant >> (5'd16 - kq));
    end
  end

  // bin position and range check
  always_comb begin
    ysum = {20'b0, plo} + {phi, 20'b0};
    y    = ysum[63:16];
    nb   = (NB_W'(num_bins) < NB_W'(MAX_BINS)) ? NB_W'(num_bins) : NB_W'(MAX_BINS);
    nbm1 = nb - NB_W'(1);
    acc_ok = (y0 != 40'd0) && (nb >= NB_W'(2)) && (y < 48'({nbm1, 16'b0}));
    acc_job.op   = acc_ok ? OP_ACC : OP_SKIP;
    acc_job.addr = y[16 +: ADDR_W];
    acc_job.frac = y[15:0];
    rd_job.op    = (int'(bidx) < MAX_BINS) ? OP_READ : OP_READ_ZERO;
    rd_job.addr  = ADDR_W'(bidx);
    rd_job.frac  = 16'd0;
  end

  assign push     = (state == ST_PUSH) && !q_full;
  assign push_job = cmd ? rd_job : acc_job;

  // one request at a time; only accumulates pass the exp and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd   <= command;
            inten <= intensity;
            bias  <= bias_log;
            bidx  <= bin_index;
            state <= command ? ST_PUSH : ST_EXP;
          end
        end
        ST_EXP: begin
          lq    <= 30'(bias) * LOG2E_Q12 + EXP_OFFS;
          y0    <= 40'(inten) * 40'(bin_scale);
          state <= ST_MANT;
        end
        ST_MANT: begin
          mant  <= t0 + 18'(tprod[20:8]);
          kq    <= lq[28:24];
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          e     <= e_next;
          state <= ST_MUL;
        end
        ST_MUL: begin
          plo   <= 44'(y0[19:0]) * 44'(e);
          phi   <= 44'(y0[39:20]) * 44'(e);
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsh_queue.sv
module bsh_queue import bsh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rptr];

  // hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_job;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/bsh_back.sv
module bsh_back import bsh_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  job_t             head,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [BIN_W-1:0] bin_value,
  output logic [CNT_W-1:0] total_count,
  output logic             accepted
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_READ,
    S_ACC0,
    S_ACC1
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_cnt;
  job_t             cur;
  logic [CNT_W-1:0] count;
  logic [BIN_W-1:0] mem [MAX_BINS];
  logic [BIN_W-1:0] rdata;

  logic             out_free;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [BIN_W-1:0] wdata;
  logic [16:0]      addend;
  logic [BIN_W:0]   sum;
  logic [CNT_W-1:0] count_inc;

  assign clearing = (state == S_CLR);
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !empty && out_free;
  assign cur_addr = AW'(cur.addr);

  // clear writes and read-modify-write datapath for the two neighbouring bins
  always_comb begin
    raddr  = (state == S_ACC0) ? cur_addr + AW'(1) : AW'(head.addr);
    addend = (state == S_ACC0) ? 17'h10000 - {1'b0, cur.frac} : {1'b0, cur.frac};
    sum    = {1'b0, rdata} + {24'b0, addend};
    we     = (state == S_CLR) || (state == S_ACC0) || (state == S_ACC1);
    case (state)
      S_CLR:   waddr = clr_cnt;
      S_ACC1:  waddr = cur_addr + AW'(1);
      default: waddr = cur_addr;
    endcase
    if (state == S_CLR) begin
      wdata = '0;
    end else if (sum[BIN_W]) begin
      wdata = '1;
    end else begin
      wdata = sum[BIN_W-1:0];
    end
    count_inc = (count == '1) ? count : count + CNT_W'(1);
  end

  // bin memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // sequence clearing, reads and accumulates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            case (head.op)
              OP_ACC:  state <= S_ACC0;
              OP_READ: state <= S_READ;
              default: begin
                out_valid   <= 1'b1;
                bin_value   <= '0;
                total_count <= count;
                accepted    <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid   <= 1'b1;
          bin_value   <= rdata;
          total_count <= count;
          accepted    <= 1'b0;
          state       <= S_IDLE;
        end
        S_ACC0: begin
          state <= S_ACC1;
        end
        S_ACC1: begin
          count       <= count_inc;
          out_valid   <= 1'b1;
          bin_value   <= '0;
          total_count <= count_inc;
          accepted    <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bias_scaled_soft_histogram.sv
// Flow: a read request goes from the front's idle state straight to its push
// state, an accumulate request first through the exp, mantissa, shift and
// multiply states; the front takes a new request only when back in idle. The
// back takes jobs from the two-entry queue and uses the bin memory in its idle,
// ACC0 and ACC1 states for each accumulate. Reset: synchronous; clears count
// and registers, then zeroes every bin, with input stalled throughout.
module bias_scaled_soft_histogram import bsh_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [15:0]          intensity,
  input  logic signed [15:0]   bias_log,
  input  logic [11:0]          bin_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BIN_W-1:0]     bin_value,
  output logic [CNT_W-1:0]     total_count,
  output logic                 accepted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  logic [SCALE_W-1:0] bin_scale;
  logic [NBREG_W-1:0] num_bins;
  logic               clearing;
  logic               push;
  job_t               push_job;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  job_t               head;

  assign cfg_ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_scale <= BIN_SCALE_RST;
      num_bins  <= NUM_BINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_SCALE: bin_scale <= cfg_data;
        CFG_NUM_BINS:  num_bins  <= cfg_data[NBREG_W-1:0];
        default: ;
      endcase
    end
  end

  bsh_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .intensity (intensity),
    .bias_log  (bias_log),
    .bin_index (bin_index),
    .bin_scale (bin_scale),
    .num_bins  (num_bins),
    .clearing  (clearing),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  bsh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  bsh_back #(.MAX_BINS(MAX_BINS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_value   (bin_value),
    .total_count (total_count),
    .accepted    (accepted)
  );

endmodule
